[rtl/core/mf3_pkg.sv]
// Shared types and constants for the 3x3 median filter.
// Used by median_filter_3x3 and mf3_median; no dependencies.
package mf3_pkg;

    // Pixel format
    localparam int PIXEL_W = 8;

    // Default size limits for the line stores and frame counters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIXEL_W-1:0] pix_t;

    // 3x3 window, row-major, top row first
    typedef pix_t [8:0] win_t;

    // Which neighbors of the output pixel lie inside the image
    typedef struct packed {
        logic last;   // output pixel is the last of the frame
        logic up;     // row above exists
        logic dn;     // row below exists
        logic lf;     // column to the left exists
        logic rt;     // column to the right exists
    } mf_nbr_t;

endpackage

[rtl/core/mf3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old contents. No dependencies.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its value while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/mf3_median.sv]
// Padded median-of-nine pipeline for the 3x3 median filter.
// Depends on mf3_pkg (win_t, mf_nbr_t, pix_t).
module mf3_median
    import mf3_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  win_t    in_win,
    input  mf_nbr_t in_nbr,
    output logic    out_valid,
    input  logic    out_ready,
    output pix_t    out_median,
    output logic    out_last
);

    // Compare-exchange: smaller value to index i, larger to index j
    function automatic win_t cx(input win_t p, input int i, input int j);
        win_t r;
        r = p;
        if (p[i] > p[j]) begin
            r[i] = p[j];
            r[j] = p[i];
        end
        return r;
    endfunction

    logic [8:0] excl;
    logic [3:0] n_keep;
    logic [3:0] n_low;
    logic [3:0] pre;
    win_t       padded;
    win_t       s1;
    win_t       s2;
    pix_t       x2, x4, y4, med;

    logic d_v_reg, e_v_reg, m_v_reg;
    logic d_ready, e_ready, m_ready;
    win_t d_win_reg;
    logic d_last_reg, e_last_reg, m_last_reg;
    pix_t e_p2_reg, e_p4_reg, e_p6_reg;
    pix_t m_med_reg;

    // Handshake chain
    assign m_ready  = !m_v_reg || out_ready;
    assign e_ready  = !e_v_reg || m_ready;
    assign d_ready  = !d_v_reg || e_ready;
    assign in_ready = d_ready;

    // Out-of-image cells become 0 or 255 so that the middle of nine is the
    // element at count/2 of the in-image values: 4 - count/2 go low, the rest high.
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                excl[row*3+col] = (row == 0 && !in_nbr.up) || (row == 2 && !in_nbr.dn) ||
                                  (col == 0 && !in_nbr.lf) || (col == 2 && !in_nbr.rt);
            end
        end
        n_keep = 4'(9 - $countones(excl));
        n_low  = 4'd4 - (n_keep >> 1);
        pre    = '0;
        for (int i = 0; i < 9; i++) begin
            pre = 4'($countones(excl & 9'((1 << i) - 1)));
            if (excl[i]) begin
                padded[i] = (pre < n_low) ? '0 : '1;
            end else begin
                padded[i] = in_win[i];
            end
        end
        // Network, first part: sort each row
        s1 = padded;
        s1 = cx(s1, 1, 2);
        s1 = cx(s1, 4, 5);
        s1 = cx(s1, 7, 8);
        s1 = cx(s1, 0, 1);
        s1 = cx(s1, 3, 4);
        s1 = cx(s1, 6, 7);
        s1 = cx(s1, 1, 2);
        s1 = cx(s1, 4, 5);
        s1 = cx(s1, 7, 8);
    end

    // Network, second part: column pruning
    always_comb begin
        s2 = d_win_reg;
        s2 = cx(s2, 0, 3);
        s2 = cx(s2, 5, 8);
        s2 = cx(s2, 4, 7);
        s2 = cx(s2, 3, 6);
        s2 = cx(s2, 1, 4);
        s2 = cx(s2, 2, 5);
        s2 = cx(s2, 4, 7);
    end

    // Network, last part: median of the three remaining candidates
    always_comb begin
        x4  = (e_p4_reg > e_p2_reg) ? e_p2_reg : e_p4_reg;
        x2  = (e_p4_reg > e_p2_reg) ? e_p4_reg : e_p2_reg;
        y4  = (e_p6_reg > x4) ? e_p6_reg : x4;
        med = (y4 > x2) ? x2 : y4;
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_v_reg <= in_valid;
            end
            if (e_ready) begin
                e_v_reg <= d_v_reg;
            end
            if (m_ready) begin
                m_v_reg <= e_v_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (in_valid && d_ready) begin
            d_win_reg  <= s1;
            d_last_reg <= in_nbr.last;
        end
        if (d_v_reg && e_ready) begin
            e_p2_reg   <= s2[2];
            e_p4_reg   <= s2[4];
            e_p6_reg   <= s2[6];
            e_last_reg <= d_last_reg;
        end
        if (e_v_reg && m_ready) begin
            m_med_reg  <= med;
            m_last_reg <= e_last_reg;
        end
    end

    assign out_valid  = m_v_reg;
    assign out_median = m_med_reg;
    assign out_last   = m_last_reg;

endmodule

[rtl/core/median_filter_3x3.sv]
// Streaming 3x3 median filter, top level.
// Depends on mf3_pkg, mf3_ram (two line stores) and mf3_median (sorting pipeline).
//
// The filter takes one 8-bit pixel per clock in raster order when not stalled and
// returns, for each pixel, the median of its in-image 3x3 neighborhood (9, 6 or 4
// values, fewer in a one-row or one-column image; the element at count/2 of the
// ascending sort). The result for raster position p is produced by the word that
// brings position p + image_width + 1, so after each frame software sends
// image_width + 1 drain words (tuser set); a drain word counts as a zero pixel.
// A result passes stage B, stage C and the median pipeline registers to the m_ side.
// The two line stores are one-port-read, one-port-write RAMs read at acceptance and
// written back as the word leaves stage B, with a bypass when consecutive words hit
// the same column. After reset and after every configuration write, s_tready stays
// low while a bit-serial divider recomputes the current position's column and row
// from the width. No clearing pass is needed: the line stores start undefined.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [7:0] pixel_value
    input  logic                  s_tuser,   // [0] drain
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // [7:0] median_value
    output logic                  m_tlast,   // frame_last
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int DCW = $clog2(PW + 1);

    function automatic logic [WW-1:0] clamp_w(input logic [WIDTH_REG_W-1:0] raw);
        logic [WW-1:0] res;
        if (raw == '0) begin
            res = WW'(1);
        end else if (int'(raw) > MAX_WIDTH) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(raw);
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [HEIGHT_REG_W-1:0] raw);
        logic [HW-1:0] res;
        if (raw == '0) begin
            res = HW'(1);
        end else if (int'(raw) > MAX_HEIGHT) begin
            res = HW'(MAX_HEIGHT);
        end else begin
            res = HW'(raw);
        end
        return res;
    endfunction

    // Sizes and frame bounds
    logic [WW-1:0]  w_reg;
    logic [HW-1:0]  h_reg;
    logic [PW-1:0]  total_reg;
    logic [PW-1:0]  end_reg;

    // Input position: t = q * w + c
    logic [PW-1:0]  t_reg;
    logic [PW-1:0]  q_reg;
    logic [CW-1:0]  c_reg;

    // Serial divider
    logic           busy_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [PW-1:0]  dq_reg, dq_next;
    logic [WW-1:0]  rem_reg, rem_next;
    logic [WW:0]    trial;
    logic           fits;

    // Per-word position decode
    logic [PW-1:0]  rp;
    logic [CW-1:0]  cp;
    logic           has_pos;
    logic           res_a;
    mf_nbr_t        nbr_a;
    logic           frame_end;
    logic           col_wrap;
    pix_t           pix_in;
    logic           s_acc;

    // Stage B: line store read data present
    logic           b_v_reg;
    pix_t           b_pix_reg;
    logic [CW-1:0]  b_col_reg;
    logic           b_res_reg;
    mf_nbr_t        b_nbr_reg;
    logic           b_fwd_reg;
    pix_t           b_fwd_top_reg, b_fwd_mid_reg;
    pix_t           up_rdata, lo_rdata;
    pix_t           top_b, mid_b;
    logic           b_ready, b_adv, fwd_hit;

    // Stage C: window holds the output pixel's neighborhood
    logic           c_v_reg;
    logic           c_res_reg;
    mf_nbr_t        c_nbr_reg;
    win_t           win_reg;
    logic           c_ready, c_adv;
    logic           med_in_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= clamp_w(WIDTH_REG_W'(WIDTH_RESET));
            h_reg <= clamp_h(HEIGHT_REG_W'(HEIGHT_RESET));
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  w_reg <= clamp_w(cfg_data[WIDTH_REG_W-1:0]);
                CFG_IMAGE_HEIGHT: h_reg <= clamp_h(cfg_data[HEIGHT_REG_W-1:0]);
                default: ;
            endcase
        end
    end

    // Frame size and end position, settled well inside the divider run
    always_ff @(posedge aclk) begin
        total_reg <= PW'(w_reg) * PW'(h_reg);
        end_reg   <= total_reg + PW'(w_reg);
    end

    // One restoring division step per cycle
    always_comb begin
        trial   = {rem_reg, dq_reg[PW-1]};
        fits    = (trial >= {1'b0, w_reg});
        rem_next = fits ? WW'(trial - {1'b0, w_reg}) : trial[WW-1:0];
        dq_next  = {dq_reg[PW-2:0], fits};
    end

    // Position of the output pixel, p = t - w - 1
    always_comb begin
        if (c_reg == '0) begin
            cp      = CW'(w_reg - WW'(1));
            rp      = q_reg - PW'(2);
            has_pos = (q_reg >= PW'(2));
        end else begin
            cp      = c_reg - CW'(1);
            rp      = q_reg - PW'(1);
            has_pos = (q_reg != '0);
        end
        res_a      = has_pos && (rp < PW'(h_reg));
        nbr_a.up   = (rp != '0);
        nbr_a.dn   = (rp != PW'(h_reg) - PW'(1));
        nbr_a.lf   = (cp != '0);
        nbr_a.rt   = (WW'(cp) != w_reg - WW'(1));
        nbr_a.last = !nbr_a.dn && !nbr_a.rt;
    end

    assign frame_end = (t_reg >= end_reg);
    assign col_wrap  = ((WW'(c_reg) + WW'(1)) == w_reg);
    assign pix_in    = s_tuser ? '0 : s_tdata;

    // Handshake chain
    assign c_adv    = c_v_reg && (!c_res_reg || med_in_ready);
    assign c_ready  = !c_v_reg || c_adv;
    assign b_adv    = b_v_reg && c_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign s_tready = !busy_reg && b_ready;
    assign s_acc    = s_tvalid && s_tready;

    // Position counters and divider control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg       <= '0;
            q_reg       <= '0;
            c_reg       <= '0;
            busy_reg    <= 1'b1;
            div_cnt_reg <= DCW'(PW);
            dq_reg      <= '0;
            rem_reg     <= '0;
        end else if (cfg_wr_en) begin
            busy_reg    <= 1'b1;
            div_cnt_reg <= DCW'(PW);
            dq_reg      <= t_reg;
            rem_reg     <= '0;
        end else if (busy_reg) begin
            if (div_cnt_reg != '0) begin
                dq_reg      <= dq_next;
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end else begin
                q_reg    <= dq_reg;
                c_reg    <= CW'(rem_reg);
                busy_reg <= 1'b0;
            end
        end else if (s_acc) begin
            if (frame_end) begin
                t_reg <= '0;
                q_reg <= '0;
                c_reg <= '0;
            end else begin
                t_reg <= t_reg + PW'(1);
                if (col_wrap) begin
                    c_reg <= '0;
                    q_reg <= q_reg + PW'(1);
                end else begin
                    c_reg <= c_reg + CW'(1);
                end
            end
        end
    end

    // Line stores: read at acceptance, written back when the word leaves stage B
    mf3_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (aclk),
        .we    (b_adv),
        .waddr (b_col_reg),
        .wdata (mid_b),
        .re    (s_acc),
        .raddr (c_reg),
        .rdata (up_rdata)
    );

    mf3_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower_store (
        .clk   (aclk),
        .we    (b_adv),
        .waddr (b_col_reg),
        .wdata (b_pix_reg),
        .re    (s_acc),
        .raddr (c_reg),
        .rdata (lo_rdata)
    );

    // Bypass: the word in stage B writes the column being read this cycle
    assign fwd_hit = b_adv && (b_col_reg == c_reg);
    assign top_b   = b_fwd_reg ? b_fwd_top_reg : up_rdata;
    assign mid_b   = b_fwd_reg ? b_fwd_mid_reg : lo_rdata;

    // Stage B
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (b_ready) begin
            b_v_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_pix_reg     <= pix_in;
            b_col_reg     <= c_reg;
            b_res_reg     <= res_a;
            b_nbr_reg     <= nbr_a;
            b_fwd_reg     <= fwd_hit;
            b_fwd_top_reg <= mid_b;
            b_fwd_mid_reg <= b_pix_reg;
        end
    end

    // Stage C: shift the window by one column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
            win_reg <= '0;
        end else begin
            if (c_ready) begin
                c_v_reg <= b_v_reg;
            end
            if (b_adv) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= top_b;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= mid_b;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= b_pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            c_res_reg <= b_res_reg;
            c_nbr_reg <= b_nbr_reg;
        end
    end

    // Median pipeline and output register
    mf3_median u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (c_v_reg && c_res_reg),
        .in_ready   (med_in_ready),
        .in_win     (win_reg),
        .in_nbr     (c_nbr_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (m_tdata),
        .out_last   (m_tlast)
    );

    // A configuration write always starts a position recompute
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> busy_reg)
        else $error("configuration write did not start the divider");

    // Column counter stays inside the row once positions are valid
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (WW'(c_reg) < w_reg))
        else $error("column counter outside the image width");

    // An accepted word lands in stage B with the column it was read at
    a_accept_b: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (b_v_reg && (b_col_reg == $past(c_reg))))
        else $error("accepted word missing from stage B");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for median_filter_3x3: streams frames of many sizes and checks
// every median word against an in-file predictor. Depends on mf3_pkg and the filter RTL.
module testbench;
    import mf3_pkg::*;

    localparam int LINE_LEN_MAX   = DEF_MAX_WIDTH;
    localparam int ROW_COUNT_MAX  = DEF_MAX_HEIGHT;
    localparam int RUN_LIMIT      = 2_000_000;
    localparam int RANDOM_WORDS   = 1850;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_GAP        = 17;
    localparam int DIRECTED_ROWS  = 25;

    // One result word: median and end-of-frame flag
    typedef struct packed {
        pix_t median;
        logic last;
    } median_word_t;

    // One row of the directed table; set_size writes both size registers first
    typedef struct packed {
        logic        set_size;
        logic [12:0] width_val;
        logic [12:0] height_val;
        pix_t        pix;
        logic        drain;
        logic        typed;
        pix_t        typed_median;
        logic        typed_last;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata;   // [7:0] pixel_value
    logic                  s_tuser;   // [0] drain
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIXEL_W-1:0]    m_tdata;   // [7:0] median_value
    logic                  m_tlast;   // frame_last
    logic                  cfg_wr_en;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    pix_t                    row_above_mem [LINE_LEN_MAX];
    pix_t                    row_cur_mem [LINE_LEN_MAX];
    pix_t                    win_px [9];
    longint unsigned         frame_word_pos;

    median_word_t expected_medians [$];
    int           mismatch_count;
    int           cycle_count;
    int           send_quiet_left;

    // Directed words: 1x1 frames (zero sizes), drain standing for a pixel,
    // a pixel dropped in the drain tail, then a 2x3 and a 3x1 frame.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, 13'd0, 13'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{1'b0, 13'd0, 13'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hC3, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h3C, 1'b1, 1'b1, 8'h00, 1'b1},
        '{1'b0, 13'd0, 13'd0, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h77, 1'b0, 1'b1, 8'h00, 1'b1},
        '{1'b1, 13'd2, 13'd3, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b1, 13'd3, 13'd1, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'h0F, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 13'd0, 13'd0, 8'hF0, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    median_filter_3x3 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Frame size as the block sees it: zero means one, large values saturate
    function automatic int unsigned eff_width();
        if (width_reg == '0) return 1;
        if (width_reg > LINE_LEN_MAX) return LINE_LEN_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == '0) return 1;
        if (height_reg > ROW_COUNT_MAX) return ROW_COUNT_MAX;
        return height_reg;
    endfunction

    // Advance the predictor by one accepted word; returns 1 when a median comes out
    function automatic logic median_predict(input pix_t pix, input logic drain,
                                            output median_word_t res);
        int unsigned     w, h, col, rp, cp;
        longint unsigned total, t, p;
        pix_t            v, top, mid;
        pix_t            vals [9];
        int              n, rr, cc, below, upto;
        logic            produced;
        w        = eff_width();
        h        = eff_height();
        total    = longint'(w) * h;
        t        = frame_word_pos;
        v        = drain ? 8'h00 : pix;
        col      = t % w;
        top      = row_above_mem[col];
        mid      = row_cur_mem[col];
        produced = 1'b0;
        res      = '0;
        row_above_mem[col] = mid;
        row_cur_mem[col]   = v;
        // shift window left, new column on the right
        for (int r = 0; r < 3; r++) begin
            win_px[r*3]   = win_px[r*3+1];
            win_px[r*3+1] = win_px[r*3+2];
        end
        win_px[2] = top;
        win_px[5] = mid;
        win_px[8] = v;
        if (t >= w + 1) begin
            p = t - w - 1;
            if (p < total) begin
                rp = p / w;
                cp = p % w;
                n  = 0;
                // keep only neighbors inside the image
                for (int dr = -1; dr <= 1; dr++) begin
                    rr = int'(rp) + dr;
                    if (rr >= 0 && rr < int'(h)) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            cc = int'(cp) + dc;
                            if (cc >= 0 && cc < int'(w)) begin
                                vals[n] = win_px[(dr+1)*3 + dc + 1];
                                n++;
                            end
                        end
                    end
                end
                // rank selection: value whose rank range covers n/2
                for (int i = 0; i < n; i++) begin
                    below = 0;
                    upto  = 0;
                    for (int j = 0; j < n; j++) begin
                        if (vals[j] < vals[i]) below++;
                        if (vals[j] <= vals[i]) upto++;
                    end
                    if (below <= n/2 && n/2 < upto) res.median = vals[i];
                end
                res.last = (p == total - 1);
                produced = 1'b1;
            end
        end
        if (t + 1 >= total + w + 1) frame_word_pos = 0;
        else frame_word_pos = t + 1;
        return produced;
    endfunction

    function automatic pix_t draw_pixel(input int mode);
        case (mode)
            0:       return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            1:       return pix_t'($urandom_range(120, 123));
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one word, wait for the handshake, then record what it should produce
    task automatic send_word(input pix_t pix, input logic drain, input logic use_typed,
                             input median_word_t typed_word);
        int           gap;
        median_word_t res;
        logic         produced;
        if (send_quiet_left > 0) begin
            send_quiet_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 29) == 0) send_quiet_left = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drain;
        do @(posedge aclk); while (s_tready !== 1'b1);
        produced = median_predict(pix, drain, res);
        if (use_typed) expected_medians.push_back(typed_word);
        else if (produced) expected_medians.push_back(res);
    endtask

    // Stop sending and let every pending median drain out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_medians.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sizes(input logic do_w, input logic do_h,
                               input logic [12:0] w_val, input logic [12:0] h_val);
        if (do_w) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IMAGE_WIDTH;
            cfg_data  <= w_val;
            @(posedge aclk);
            width_reg = w_val[WIDTH_REG_W-1:0];
        end
        if (do_h) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IMAGE_HEIGHT;
            cfg_data  <= h_val;
            @(posedge aclk);
            height_reg = h_val;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random stalls, long hold-offs now and then, checking
    initial begin
        int           wait_left;
        int           hold_left;
        int           recv_quiet_left;
        int           results_seen;
        median_word_t want;
        wait_left       = 0;
        hold_left       = 0;
        recv_quiet_left = 0;
        results_seen    = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                results_seen++;
                if (expected_medians.size() == 0) begin
                    $display("%0t: median word with none pending: got %02h last %0b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_medians.pop_front();
                    if (m_tdata !== want.median || m_tlast !== want.last) begin
                        $display("%0t: median mismatch: expected %02h last %0b, got %02h last %0b",
                                 $time, want.median, want.last, m_tdata, m_tlast);
                        mismatch_count++;
                    end
                end
                if (recv_quiet_left > 0) begin
                    recv_quiet_left--;
                    wait_left = 0;
                end else begin
                    wait_left = $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 29) == 0) recv_quiet_left = $urandom_range(10, 60);
                end
                // long back-pressure so the block fills and stalls its input
                if (results_seen % 512 == 100) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        median_word_t typed_word;
        int           sent_random;
        int           phase;
        int           frames;
        int           pick;
        int           pix_mode;
        logic         big;
        logic         noisy;
        logic         drain;
        logic [12:0]  new_w;
        logic [12:0]  new_h;
        int unsigned  pixels;
        int unsigned  frame_len;

        cycle_count     = 0;
        mismatch_count  = 0;
        send_quiet_left = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;

        // predictor reset state
        width_reg      = WIDTH_RESET;
        height_reg     = HEIGHT_RESET;
        frame_word_pos = 0;
        for (int i = 0; i < LINE_LEN_MAX; i++) begin
            row_above_mem[i] = '0;
            row_cur_mem[i]   = '0;
        end
        for (int i = 0; i < 9; i++) win_px[i] = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].set_size) begin
                wait_idle();
                write_sizes(1'b1, 1'b1, directed_rows[i].width_val, directed_rows[i].height_val);
            end
            typed_word.median = directed_rows[i].typed_median;
            typed_word.last   = directed_rows[i].typed_last;
            send_word(directed_rows[i].pix, directed_rows[i].drain, directed_rows[i].typed,
                      typed_word);
        end

        // random frames; two phases take the largest sizes
        sent_random = 0;
        phase       = 0;
        while (sent_random < RANDOM_WORDS) begin
            phase++;
            big = 1'b0;
            if (phase == 3) begin
                new_w = 13'h1FFF;
                new_h = 13'd1;
                big   = 1'b1;
            end else if (phase == 8) begin
                new_w = 13'd1;
                new_h = 13'h1FFF;
                big   = 1'b1;
            end else begin
                case ($urandom_range(0, 7))
                    0: begin
                        new_w = $urandom_range(0, 1);
                        new_h = $urandom_range(1, 12);
                    end
                    1: begin
                        new_w = $urandom_range(1, 16);
                        new_h = $urandom_range(0, 1);
                    end
                    2: begin
                        new_w = $urandom_range(13, 40);
                        new_h = $urandom_range(2, 4);
                    end
                    default: begin
                        new_w = $urandom_range(1, 12);
                        new_h = $urandom_range(1, 10);
                    end
                endcase
            end
            wait_idle();
            // sometimes rewrite only one register, but never next to a large size
            pick = $urandom_range(1, 5);
            if (big || eff_width() > 40 || eff_height() > 12) pick = 3;
            write_sizes(pick != 2, pick != 1, new_w, new_h);

            frames = big ? 1 : $urandom_range(1, 3);
            repeat (frames) begin
                pixels    = eff_width() * eff_height();
                frame_len = pixels + eff_width() + 1;
                noisy     = ($urandom_range(0, 4) == 0);
                pix_mode  = $urandom_range(0, 3);
                for (int unsigned i = 0; i < frame_len; i++) begin
                    drain = (i >= pixels);
                    if (noisy && $urandom_range(0, 7) == 0) drain = !drain;
                    send_word(draw_pixel(pix_mode), drain, 1'b0, '0);
                    if (!big) sent_random++;
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/mf3_pkg.sv
rtl/core/mf3_ram.sv
rtl/core/mf3_median.sv
rtl/core/median_filter_3x3.sv
sim/testbench.sv
